// ----- rtl/rmd_pkg.sv -----
// rmd_pkg: shared codes and types of the rpc message deframer
// parse phases, item kinds, status codes, register indexes, queue entry type
// no dependencies
package rmd_pkg;

    localparam logic [4:0] PH_HDR      = 5'd0;
    localparam logic [4:0] PH_ID       = 5'd1;
    localparam logic [4:0] PH_ERR      = 5'd2;
    localparam logic [4:0] PH_NAME_LEN = 5'd3;
    localparam logic [4:0] PH_NAME_B   = 5'd4;
    localparam logic [4:0] PH_MSG_LEN  = 5'd5;
    localparam logic [4:0] PH_MSG_B    = 5'd6;
    localparam logic [4:0] PH_PAY_LEN  = 5'd7;
    localparam logic [4:0] PH_PAY_B    = 5'd8;
    localparam logic [4:0] PH_TIMEOUT  = 5'd9;
    localparam logic [4:0] PH_META_CNT = 5'd10;
    localparam logic [4:0] PH_KEY_LEN  = 5'd11;
    localparam logic [4:0] PH_KEY_B    = 5'd12;
    localparam logic [4:0] PH_VAL_LEN  = 5'd13;
    localparam logic [4:0] PH_VAL_B    = 5'd14;
    localparam logic [4:0] PH_SKIP     = 5'd15;
    localparam logic [4:0] PH_PAY_END  = 5'd16;
    localparam logic [4:0] PH_PAIR_END = 5'd17;

    localparam logic [3:0] K_ID       = 4'd0;
    localparam logic [3:0] K_TIMEOUT  = 4'd1;
    localparam logic [3:0] K_ERRCODE  = 4'd2;
    localparam logic [3:0] K_NAME_LEN = 4'd3;
    localparam logic [3:0] K_NAME_B   = 4'd4;
    localparam logic [3:0] K_MSG_LEN  = 4'd5;
    localparam logic [3:0] K_MSG_B    = 4'd6;
    localparam logic [3:0] K_PAY_LEN  = 4'd7;
    localparam logic [3:0] K_PAY_B    = 4'd8;
    localparam logic [3:0] K_META_CNT = 4'd9;
    localparam logic [3:0] K_KEY_LEN  = 4'd10;
    localparam logic [3:0] K_KEY_B    = 4'd11;
    localparam logic [3:0] K_VAL_LEN  = 4'd12;
    localparam logic [3:0] K_VAL_B    = 4'd13;
    localparam logic [3:0] K_STATUS   = 4'd14;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SHORT   = 3'd1;
    localparam logic [2:0] ST_MAGIC   = 3'd2;
    localparam logic [2:0] ST_VERSION = 3'd3;
    localparam logic [2:0] ST_TYPE    = 3'd4;
    localparam logic [2:0] ST_TRUNC   = 3'd5;
    localparam logic [2:0] ST_BIG     = 3'd6;

    localparam logic [2:0] CFG_MAGIC    = 3'd0;
    localparam logic [2:0] CFG_VERSION  = 3'd1;
    localparam logic [2:0] CFG_REQ_TYPE = 3'd2;
    localparam logic [2:0] CFG_RSP_TYPE = 3'd3;
    localparam logic [2:0] CFG_MAX_PAY  = 3'd4;
    localparam logic [2:0] CFG_PARSE_RSP = 3'd5;

    localparam logic [3:0] HDR_MAGIC_END = 4'd4;
    localparam logic [3:0] HDR_VER_END   = 4'd8;
    localparam logic [3:0] HDR_BYTES     = 4'd12;

    // one queue entry: the results caused by one input byte
    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] value;
        logic [2:0]  status;
        logic        has_status2;   // a status result follows the first one
        logic [2:0]  status2;
    } rmd_entry_t;

endpackage

// ----- rtl/rpc_message_deframer.sv -----
// rpc_message_deframer: top level of the length-prefixed rpc message parser
// channel   dir  data                                    marker
// s_        in   tdata[7:0] data_byte                    tlast frame_last
// m_        out  tdata kind, value, status (40 bits)     tlast run_last
// cfg_      in   index 0..5, 32-bit write data           write enable
// one byte word is taken per cycle while the queue has room; the parser updates its
// state once per byte and its results go through the queue to m_. the output stage
// sends one result word per cycle while m_tready is high, so a byte with two results
// takes one extra output word that the queue absorbs; bytes with no result use no
// queue entry. reset is synchronous and clears parser state, queue and registers.
// a stalled output fills the QUEUE_DEPTH-entry queue before s_tready drops.
// depends on rmd_pkg, rmd_front, rmd_queue, rmd_back
module rpc_message_deframer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,     // [3:0] item_kind, [35:4] item_value,
                                     // [38:36] status_code, [39] zero
    output logic        m_tlast
);
    import rmd_pkg::*;

    logic       in_accept, push, pop, full, head_valid;
    rmd_entry_t push_entry, head_entry;

    assign s_tready  = !full;
    assign in_accept = s_tvalid && s_tready;

    rmd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_accept  (in_accept),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .push       (push),
        .push_entry (push_entry)
    );

    rmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    rmd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ----- rtl/rmd_front.sv -----
// rmd_front: configuration registers and byte parser of the deframer
// classifies each accepted byte and builds one queue entry of up to two results
// depends on rmd_pkg
module rmd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_wdata,
    input  logic                in_accept,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output logic                push,
    output rmd_pkg::rmd_entry_t push_entry
);
    import rmd_pkg::*;

    logic [31:0] magic_reg, version_reg, req_type_reg, rsp_type_reg, max_pay_reg;
    logic        parse_rsp_reg;

    logic [4:0]  phase_reg, phase_next;
    logic [1:0]  biw_reg, biw_next;
    logic [31:0] ws_reg, ws_next;
    logic [3:0]  hbs_reg, hbs_next;
    logic [31:0] br_reg, br_next;
    logic [31:0] pr_reg, pr_next;
    logic [2:0]  fault_reg, fault_next;
    logic        settled_reg, settled_next;

    logic [31:0] ws_sh, expect_word;
    logic [2:0]  hdr_code;
    logic        item_v, stl_v, ent_v;
    logic [3:0]  item_kind;
    logic [31:0] item_value;
    logic [2:0]  stl_code;
    logic [4:0]  ent_ph;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg     <= '0;
            version_reg   <= '0;
            req_type_reg  <= '0;
            rsp_type_reg  <= '0;
            max_pay_reg   <= '1;
            parse_rsp_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MAGIC:     magic_reg     <= cfg_wdata;
                CFG_VERSION:   version_reg   <= cfg_wdata;
                CFG_REQ_TYPE:  req_type_reg  <= cfg_wdata;
                CFG_RSP_TYPE:  rsp_type_reg  <= cfg_wdata;
                CFG_MAX_PAY:   max_pay_reg   <= cfg_wdata;
                CFG_PARSE_RSP: parse_rsp_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign ws_sh = {ws_reg[23:0], in_byte};

    always_comb begin
        phase_next   = phase_reg;
        biw_next     = biw_reg;
        ws_next      = ws_reg;
        hbs_next     = hbs_reg;
        br_next      = br_reg;
        pr_next      = pr_reg;
        fault_next   = fault_reg;
        settled_next = settled_reg;
        item_v       = 1'b0;
        item_kind    = K_ID;
        item_value   = '0;
        stl_v        = 1'b0;
        stl_code     = ST_OK;
        ent_v        = 1'b0;
        ent_ph       = PH_HDR;
        expect_word  = magic_reg;
        hdr_code     = ST_MAGIC;

        if (!settled_reg) begin
            case (phase_reg)
                PH_HDR: begin
                    hbs_next = hbs_reg + 4'd1;
                    ws_next  = ws_sh;
                    if (hbs_next[1:0] == 2'd0) begin
                        if (hbs_next == HDR_MAGIC_END) begin
                            expect_word = magic_reg;
                            hdr_code    = ST_MAGIC;
                        end else if (hbs_next == HDR_VER_END) begin
                            expect_word = version_reg;
                            hdr_code    = ST_VERSION;
                        end else begin
                            expect_word = parse_rsp_reg ? rsp_type_reg : req_type_reg;
                            hdr_code    = ST_TYPE;
                        end
                        // only the first mismatch is kept
                        if (fault_reg == ST_OK && ws_sh != expect_word) begin
                            fault_next = hdr_code;
                        end
                        ws_next = '0;
                    end
                    if (hbs_next == HDR_BYTES) begin
                        if (fault_next != ST_OK) begin
                            stl_v    = 1'b1;
                            stl_code = fault_next;
                        end else begin
                            phase_next = PH_ID;
                        end
                    end
                end
                PH_SKIP: begin
                    br_next = br_reg - 32'd1;
                    if (br_next == '0) begin
                        stl_v    = 1'b1;
                        stl_code = ST_BIG;
                    end
                end
                PH_NAME_B, PH_MSG_B, PH_PAY_B, PH_KEY_B, PH_VAL_B: begin
                    item_v     = 1'b1;
                    item_value = {24'd0, in_byte};
                    br_next    = br_reg - 32'd1;
                    case (phase_reg)
                        PH_NAME_B: begin item_kind = K_NAME_B; ent_ph = PH_PAY_LEN;  end
                        PH_MSG_B:  begin item_kind = K_MSG_B;  ent_ph = PH_PAY_LEN;  end
                        PH_PAY_B:  begin item_kind = K_PAY_B;  ent_ph = PH_PAY_END;  end
                        PH_KEY_B:  begin item_kind = K_KEY_B;  ent_ph = PH_VAL_LEN;  end
                        default:   begin item_kind = K_VAL_B;  ent_ph = PH_PAIR_END; end
                    endcase
                    ent_v = (br_next == '0);
                end
                default: begin
                    ws_next  = ws_sh;
                    biw_next = biw_reg + 2'd1;
                    if (biw_next == 2'd0) begin
                        ws_next    = '0;
                        item_v     = 1'b1;
                        item_value = ws_sh;
                        case (phase_reg)
                            PH_ID: begin
                                item_kind  = K_ID;
                                phase_next = parse_rsp_reg ? PH_ERR : PH_NAME_LEN;
                            end
                            PH_ERR: begin
                                item_kind  = K_ERRCODE;
                                phase_next = PH_MSG_LEN;
                            end
                            PH_TIMEOUT: begin
                                item_kind  = K_TIMEOUT;
                                phase_next = PH_META_CNT;
                            end
                            PH_NAME_LEN: begin
                                item_kind = K_NAME_LEN;
                                if (ws_sh == '0) begin
                                    ent_v  = 1'b1;
                                    ent_ph = PH_PAY_LEN;
                                end else begin
                                    br_next    = ws_sh;
                                    phase_next = PH_NAME_B;
                                end
                            end
                            PH_MSG_LEN: begin
                                item_kind = K_MSG_LEN;
                                if (ws_sh == '0) begin
                                    ent_v  = 1'b1;
                                    ent_ph = PH_PAY_LEN;
                                end else begin
                                    br_next    = ws_sh;
                                    phase_next = PH_MSG_B;
                                end
                            end
                            PH_PAY_LEN: begin
                                item_kind = K_PAY_LEN;
                                if (ws_sh > max_pay_reg) begin
                                    // oversize: count the bytes, emit none
                                    br_next    = ws_sh;
                                    phase_next = PH_SKIP;
                                end else if (ws_sh == '0) begin
                                    ent_v  = 1'b1;
                                    ent_ph = PH_PAY_END;
                                end else begin
                                    br_next    = ws_sh;
                                    phase_next = PH_PAY_B;
                                end
                            end
                            PH_META_CNT: begin
                                item_kind = K_META_CNT;
                                pr_next   = ws_sh;
                                if (ws_sh == '0) begin
                                    stl_v    = 1'b1;
                                    stl_code = ST_OK;
                                end else begin
                                    phase_next = PH_KEY_LEN;
                                end
                            end
                            PH_KEY_LEN: begin
                                item_kind = K_KEY_LEN;
                                if (ws_sh == '0) begin
                                    ent_v  = 1'b1;
                                    ent_ph = PH_VAL_LEN;
                                end else begin
                                    br_next    = ws_sh;
                                    phase_next = PH_KEY_B;
                                end
                            end
                            default: begin
                                item_kind = K_VAL_LEN;
                                if (ws_sh == '0) begin
                                    ent_v  = 1'b1;
                                    ent_ph = PH_PAIR_END;
                                end else begin
                                    br_next    = ws_sh;
                                    phase_next = PH_VAL_B;
                                end
                            end
                        endcase
                    end
                end
            endcase
        end

        // move on once a string, payload or pair is complete
        if (ent_v) begin
            case (ent_ph)
                PH_PAIR_END: begin
                    pr_next = pr_reg - 32'd1;
                    if (pr_next == '0) begin
                        stl_v    = 1'b1;
                        stl_code = ST_OK;
                    end else begin
                        phase_next = PH_KEY_LEN;
                    end
                end
                PH_PAY_END: phase_next = parse_rsp_reg ? PH_META_CNT : PH_TIMEOUT;
                default:    phase_next = ent_ph;
            endcase
        end

        if (stl_v) begin
            settled_next = 1'b1;
        end

        if (in_last) begin
            if (!settled_reg && !stl_v) begin
                stl_v    = 1'b1;
                stl_code = (phase_next == PH_HDR && hbs_next < HDR_BYTES) ? ST_SHORT : ST_TRUNC;
            end
            phase_next   = PH_HDR;
            biw_next     = '0;
            ws_next      = '0;
            hbs_next     = '0;
            br_next      = '0;
            pr_next      = '0;
            fault_next   = ST_OK;
            settled_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HDR;
            biw_reg     <= '0;
            ws_reg      <= '0;
            hbs_reg     <= '0;
            br_reg      <= '0;
            pr_reg      <= '0;
            fault_reg   <= ST_OK;
            settled_reg <= 1'b0;
        end else if (in_accept) begin
            phase_reg   <= phase_next;
            biw_reg     <= biw_next;
            ws_reg      <= ws_next;
            hbs_reg     <= hbs_next;
            br_reg      <= br_next;
            pr_reg      <= pr_next;
            fault_reg   <= fault_next;
            settled_reg <= settled_next;
        end
    end

    assign push = in_accept && (item_v || stl_v);

    always_comb begin
        if (item_v) begin
            push_entry.kind        = item_kind;
            push_entry.value       = item_value;
            push_entry.status      = ST_OK;
            push_entry.has_status2 = stl_v;
            push_entry.status2     = stl_code;
        end else begin
            push_entry.kind        = K_STATUS;
            push_entry.value       = '0;
            push_entry.status      = stl_code;
            push_entry.has_status2 = 1'b0;
            push_entry.status2     = ST_OK;
        end
    end

endmodule

// ----- rtl/rmd_queue.sv -----
// rmd_queue: short queue of parsed entries between the parser and the output stage
// register array with read and write pointers and a fill count
// depends on rmd_pkg
module rmd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  rmd_pkg::rmd_entry_t push_entry,
    input  logic                pop,
    output logic                full,
    output logic                head_valid,
    output rmd_pkg::rmd_entry_t head_entry
);
    import rmd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rmd_entry_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- rtl/rmd_back.sv -----
// rmd_back: output stage of the deframer
// splits a queue entry into one or two result words and marks the last of them
// depends on rmd_pkg
module rmd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  rmd_pkg::rmd_entry_t head_entry,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,
    output logic                m_tlast
);
    import rmd_pkg::*;

    logic       sub_reg;   // second word of the entry is on the port
    logic [3:0] kind;
    logic [31:0] value;
    logic [2:0] status;
    logic       take;

    assign m_tvalid = head_valid;
    assign take     = m_tvalid && m_tready;

    always_comb begin
        if (sub_reg) begin
            kind    = K_STATUS;
            value   = '0;
            status  = head_entry.status2;
            m_tlast = 1'b1;
        end else begin
            kind    = head_entry.kind;
            value   = head_entry.value;
            status  = head_entry.status;
            m_tlast = !head_entry.has_status2;
        end
    end

    assign m_tdata = {1'b0, status, value, kind};
    assign pop     = take && m_tlast;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg <= 1'b0;
        end else if (take) begin
            sub_reg <= !m_tlast;
        end
    end

endmodule

// ----- rtl/rmd_checker.sv -----
// rmd_checker: port-level checks on the deframer result channel
// bound to rpc_message_deframer; depends on rmd_pkg
module rmd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);
    import rmd_pkg::*;

    // a status always closes the run of its byte
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3:0] == K_STATUS) |-> m_tlast)
        else $error("status word without tlast");

    // only status words carry a status code
    a_code_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3:0] != K_STATUS) |-> (m_tdata[38:36] == ST_OK && !m_tdata[39]))
        else $error("status code on a non-status word");

    // reset empties the output side
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result word changed");

endmodule

bind rpc_message_deframer rmd_checker u_rmd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- verif/rpc_message_deframer_tb.sv -----
// rpc_message_deframer_tb: self-checking bench for the rpc message deframer
// drives frame bytes on s_, predicts every result word and checks m_ in order
// depends on rmd_pkg and rpc_message_deframer
module rpc_message_deframer_tb;
    import rmd_pkg::*;

    localparam logic [2:0] CFG_UNUSED   = 3'd7;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned HOLD_CYCLES = 150;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] value;
        logic [2:0]  status;
        logic        run_last;
    } deframed_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [7:0] data_byte
    logic        s_tlast = 1'b0;    // frame_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [3:0] kind, [35:4] value, [38:36] status, [39] zero
    logic        m_tlast;           // run_last

    rpc_message_deframer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // predictor copy of the registers and the frame parser
    logic [31:0] reg_magic, reg_version, reg_req_type, reg_rsp_type, reg_max_pay;
    logic        reg_rsp_layout;
    logic [4:0]  fr_phase;
    logic [1:0]  fr_nib;
    logic [31:0] fr_shift;
    logic [3:0]  fr_hdr_cnt;
    logic [31:0] fr_left;
    logic [31:0] fr_pairs;
    logic [2:0]  fr_fault;
    logic        fr_done;

    deframed_item_t expected_items[$];
    logic [7:0]     frame_bytes[$];
    bit             frame_open_ended;

    int unsigned mismatch_count = 0;
    int unsigned sent_bytes = 0;
    int unsigned quiet_cycles = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int unsigned rx_hold_requests = 0;
    int unsigned rx_hold_seen = 0;
    int unsigned rx_hold_left = 0;

    function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            CFG_MAGIC:     reg_magic = val;
            CFG_VERSION:   reg_version = val;
            CFG_REQ_TYPE:  reg_req_type = val;
            CFG_RSP_TYPE:  reg_rsp_type = val;
            CFG_MAX_PAY:   reg_max_pay = val;
            CFG_PARSE_RSP: reg_rsp_layout = val[0];
            default: ;
        endcase
    endfunction

    function automatic void clear_frame();
        fr_phase = PH_HDR;
        fr_nib = '0;
        fr_shift = '0;
        fr_hdr_cnt = '0;
        fr_left = '0;
        fr_pairs = '0;
        fr_fault = ST_OK;
        fr_done = 1'b0;
    endfunction

    function automatic void push_result(logic [3:0] kind, logic [31:0] value,
                                        logic [2:0] status);
        expected_items.push_back('{kind, value, status, 1'b0});
    endfunction

    function automatic void settle_frame(logic [2:0] code);
        push_result(K_STATUS, 32'd0, code);
        fr_done = 1'b1;
    endfunction

    function automatic void advance_to(logic [4:0] ph);
        if (ph == PH_PAIR_END) begin
            fr_pairs = fr_pairs - 32'd1;
            if (fr_pairs == 32'd0)
                settle_frame(ST_OK);
            else
                fr_phase = PH_KEY_LEN;
        end else if (ph == PH_PAY_END) begin
            fr_phase = reg_rsp_layout ? PH_META_CNT : PH_TIMEOUT;
        end else begin
            fr_phase = ph;
        end
    endfunction

    function automatic void open_content(logic [31:0] len, logic [4:0] bytes_ph,
                                         logic [4:0] after);
        if (len == 32'd0) begin
            advance_to(after);
        end else begin
            fr_left = len;
            fr_phase = bytes_ph;
        end
    endfunction

    function automatic void word_complete(logic [31:0] w);
        case (fr_phase)
            PH_ID: begin
                push_result(K_ID, w, ST_OK);
                fr_phase = reg_rsp_layout ? PH_ERR : PH_NAME_LEN;
            end
            PH_ERR: begin
                push_result(K_ERRCODE, w, ST_OK);
                fr_phase = PH_MSG_LEN;
            end
            PH_TIMEOUT: begin
                push_result(K_TIMEOUT, w, ST_OK);
                fr_phase = PH_META_CNT;
            end
            PH_NAME_LEN: begin
                push_result(K_NAME_LEN, w, ST_OK);
                open_content(w, PH_NAME_B, PH_PAY_LEN);
            end
            PH_MSG_LEN: begin
                push_result(K_MSG_LEN, w, ST_OK);
                open_content(w, PH_MSG_B, PH_PAY_LEN);
            end
            PH_PAY_LEN: begin
                push_result(K_PAY_LEN, w, ST_OK);
                if (w > reg_max_pay) begin
                    fr_left = w;
                    fr_phase = PH_SKIP;
                end else begin
                    open_content(w, PH_PAY_B, PH_PAY_END);
                end
            end
            PH_META_CNT: begin
                push_result(K_META_CNT, w, ST_OK);
                fr_pairs = w;
                if (w == 32'd0)
                    settle_frame(ST_OK);
                else
                    fr_phase = PH_KEY_LEN;
            end
            PH_KEY_LEN: begin
                push_result(K_KEY_LEN, w, ST_OK);
                open_content(w, PH_KEY_B, PH_VAL_LEN);
            end
            default: begin
                push_result(K_VAL_LEN, w, ST_OK);
                open_content(w, PH_VAL_B, PH_PAIR_END);
            end
        endcase
    endfunction

    function automatic void content_in(logic [3:0] kind, logic [7:0] b, logic [4:0] after);
        push_result(kind, {24'd0, b}, ST_OK);
        fr_left = fr_left - 32'd1;
        if (fr_left == 32'd0)
            advance_to(after);
    endfunction

    // works out every result one accepted byte causes
    function automatic void deframe_byte(logic [7:0] b, logic last);
        int unsigned n0;
        logic [31:0] want;
        logic [2:0]  code;
        logic [31:0] w;
        n0 = expected_items.size();
        if (!fr_done) begin
            if (fr_phase == PH_HDR) begin
                fr_hdr_cnt = fr_hdr_cnt + 4'd1;
                fr_shift = {fr_shift[23:0], b};
                if (fr_hdr_cnt[1:0] == 2'd0) begin
                    if (fr_hdr_cnt == HDR_MAGIC_END) begin
                        want = reg_magic;
                        code = ST_MAGIC;
                    end else if (fr_hdr_cnt == HDR_VER_END) begin
                        want = reg_version;
                        code = ST_VERSION;
                    end else begin
                        want = reg_rsp_layout ? reg_rsp_type : reg_req_type;
                        code = ST_TYPE;
                    end
                    // only the first bad header word is kept
                    if (fr_fault == ST_OK && fr_shift != want)
                        fr_fault = code;
                    fr_shift = '0;
                end
                if (fr_hdr_cnt == HDR_BYTES) begin
                    if (fr_fault != ST_OK)
                        settle_frame(fr_fault);
                    else
                        fr_phase = PH_ID;
                end
            end else begin
                case (fr_phase)
                    PH_SKIP: begin
                        fr_left = fr_left - 32'd1;
                        if (fr_left == 32'd0)
                            settle_frame(ST_BIG);
                    end
                    PH_NAME_B: content_in(K_NAME_B, b, PH_PAY_LEN);
                    PH_MSG_B:  content_in(K_MSG_B, b, PH_PAY_LEN);
                    PH_PAY_B:  content_in(K_PAY_B, b, PH_PAY_END);
                    PH_KEY_B:  content_in(K_KEY_B, b, PH_VAL_LEN);
                    PH_VAL_B:  content_in(K_VAL_B, b, PH_PAIR_END);
                    default: begin
                        fr_shift = {fr_shift[23:0], b};
                        fr_nib = fr_nib + 2'd1;
                        if (fr_nib == 2'd0) begin
                            w = fr_shift;
                            fr_shift = '0;
                            word_complete(w);
                        end
                    end
                endcase
            end
        end
        if (last) begin
            if (!fr_done) begin
                if (fr_phase == PH_HDR && fr_hdr_cnt < HDR_BYTES)
                    settle_frame(ST_SHORT);
                else
                    settle_frame(ST_TRUNC);
            end
            clear_frame();
        end
        if (expected_items.size() > n0)
            expected_items[expected_items.size() - 1].run_last = 1'b1;
    endfunction

    // frame building
    function automatic void put_word(logic [31:0] w);
        frame_bytes.push_back(w[31:24]);
        frame_bytes.push_back(w[23:16]);
        frame_bytes.push_back(w[15:8]);
        frame_bytes.push_back(w[7:0]);
    endfunction

    function automatic void put_random(int unsigned n);
        repeat (n) frame_bytes.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void put_header(bit rsp_frame, int unsigned fault_pct);
        logic [31:0] m, v, t;
        m = reg_magic;
        v = reg_version;
        t = rsp_frame ? reg_rsp_type : reg_req_type;
        if ($urandom_range(99) < fault_pct) m = m ^ ($urandom | 32'd1);
        if ($urandom_range(99) < fault_pct) v = v ^ ($urandom | 32'd1);
        if ($urandom_range(99) < fault_pct) t = t ^ ($urandom | 32'd1);
        put_word(m);
        put_word(v);
        put_word(t);
    endfunction

    // a huge length means the frame can only end truncated
    function automatic logic [31:0] pick_len(int unsigned hi);
        if ($urandom_range(99) < 3) begin
            frame_open_ended = 1'b1;
            return $urandom | 32'h8000_0000;
        end
        return 32'($urandom_range(hi));
    endfunction

    function automatic bit put_string(int unsigned hi);
        logic [31:0] len;
        len = pick_len(hi);
        put_word(len);
        if (frame_open_ended)
            return 1'b0;
        put_random(len);
        return 1'b1;
    endfunction

    function automatic void build_frame();
        logic [31:0] len;
        logic [31:0] pairs;
        frame_bytes.delete();
        frame_open_ended = 1'b0;
        put_header(reg_rsp_layout ^ ($urandom_range(99) < 5), 8);
        put_word($urandom);
        if (reg_rsp_layout)
            put_word($urandom);
        // service name for requests, message text for responses
        if (!put_string(5))
            return;
        len = pick_len(8);
        put_word(len);
        if (frame_open_ended)
            return;
        put_random(len);
        if (!reg_rsp_layout)
            put_word($urandom);
        pairs = pick_len(3);
        put_word(pairs);
        if (frame_open_ended)
            return;
        repeat (pairs) begin
            if (!put_string(4))
                return;
            if (!put_string(4))
                return;
        end
    endfunction

    // one word on s_, held until taken
    task automatic send_byte(logic [7:0] b, logic last);
        if (tx_idle_on && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        deframe_byte(b, last);
        sent_bytes++;
    endtask

    task automatic send_frame_upto(int unsigned cut);
        for (int unsigned i = 0; i < cut; i++)
            send_byte(frame_bytes[i], i == cut - 1);
    endtask

    task automatic send_random_frame();
        int unsigned roll;
        int unsigned cut;
        roll = $urandom_range(99);
        if (roll < 10) begin
            frame_bytes.delete();
            put_random($urandom_range(1, 16));
        end else if (!frame_open_ended && roll >= 25 && roll < 45) begin
            put_random($urandom_range(1, 3));
        end
        cut = frame_bytes.size();
        if (roll >= 10) begin
            if (frame_open_ended)
                cut = $urandom_range(1, cut);
            else if (roll < 25)
                cut = $urandom_range(1, cut - 1);
        end
        send_frame_upto(cut);
    endtask

    task automatic run_random(int unsigned nbytes);
        int unsigned start;
        start = sent_bytes;
        while (sent_bytes - start < nbytes) begin
            build_frame();
            send_random_frame();
        end
    endtask

    task automatic drain_idle();
        s_tvalid <= 1'b0;
        while (expected_items.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        apply_reg(idx, val);
    endtask

    task automatic program_regs(logic [31:0] magic, logic [31:0] ver, logic [31:0] req,
                                logic [31:0] rsp, logic [31:0] max_pay,
                                logic [31:0] layout);
        drain_idle();
        write_reg(CFG_UNUSED, $urandom);
        write_reg(CFG_MAGIC, magic);
        write_reg(CFG_VERSION, ver);
        write_reg(CFG_REQ_TYPE, req);
        write_reg(CFG_RSP_TYPE, rsp);
        write_reg(CFG_MAX_PAY, max_pay);
        write_reg(CFG_PARSE_RSP, layout);
        cfg_we <= 1'b0;
    endtask

    // tests
    task automatic test_short_header();
        frame_bytes.delete();
        frame_bytes.push_back(8'hFF);
        send_frame_upto(1);
        frame_bytes.delete();
        put_word(32'd0);
        frame_bytes.push_back(8'h00);
        send_frame_upto(5);
    endtask

    task automatic test_header_checks();
        // magic and version both bad: magic reported
        frame_bytes.delete();
        put_word(32'd1);
        put_word(32'hFFFF_FFFF);
        put_word(32'd0);
        send_frame_upto(12);
        frame_bytes.delete();
        put_word(32'd0);
        put_word(32'd2);
        put_word(32'd0);
        send_frame_upto(12);
        frame_bytes.delete();
        put_word(32'd0);
        put_word(32'd0);
        put_word(32'h8000_0000);
        frame_bytes.push_back(8'h5A);
        send_frame_upto(13);
        // good header that ends on its last byte
        frame_bytes.delete();
        put_header(1'b0, 0);
        send_frame_upto(12);
    endtask

    task automatic test_request_layout();
        frame_bytes.delete();
        put_header(1'b0, 0);
        put_word(32'hFFFF_FFFF);
        put_word(32'd1);
        frame_bytes.push_back(8'hFF);
        put_word(32'd2);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hFF);
        put_word(32'h1234_5678);
        put_word(32'd1);
        put_word(32'd0);
        put_word(32'd1);
        frame_bytes.push_back(8'h80);
        frame_bytes.push_back(8'hAA);
        frame_bytes.push_back(8'h55);
        send_frame_upto(frame_bytes.size());
    endtask

    task automatic test_oversize();
        program_regs(32'hA5C3_0F01, 32'd1, 32'd2, 32'd3, 32'd1, 32'd0);
        frame_bytes.delete();
        put_header(1'b0, 0);
        put_word(32'd7);
        put_word(32'd0);
        put_word(32'd3);
        put_random(3);
        frame_bytes.push_back(8'h00);
        send_frame_upto(frame_bytes.size());
        // oversize cut short reports truncation
        frame_bytes.delete();
        put_header(1'b0, 0);
        put_word(32'd8);
        put_word(32'd0);
        put_word(32'd3);
        put_random(2);
        send_frame_upto(frame_bytes.size());
        // payload at the limit, frame ends on the metadata count
        frame_bytes.delete();
        put_header(1'b0, 0);
        put_word(32'd9);
        put_word(32'd0);
        put_word(32'd1);
        put_random(1);
        put_word(32'hFFFF_FFFF);
        put_word(32'd0);
        send_frame_upto(frame_bytes.size());
    endtask

    task automatic test_response_layout();
        program_regs(32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF);
        frame_bytes.delete();
        put_header(1'b1, 0);
        put_word(32'd5);
        put_word(32'h8000_0001);
        put_word(32'd2);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hFF);
        put_word(32'd0);
        put_word(32'd0);
        send_frame_upto(frame_bytes.size());
        frame_bytes.delete();
        put_header(1'b1, 0);
        put_word(32'd6);
        put_word(32'd0);
        put_word(32'd3);
        frame_bytes.push_back(8'h7F);
        send_frame_upto(frame_bytes.size());
        // request type word while parsing responses
        frame_bytes.delete();
        put_header(1'b0, 0);
        put_random(4);
        send_frame_upto(frame_bytes.size());
    endtask

    task automatic test_random_request();
        program_regs(32'hA5C3_0F01, 32'd2, 32'h11, 32'h22, 32'hFFFF_FFFF, 32'd0);
        run_random(200);
    endtask

    task automatic test_random_response_no_gaps();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'h5A5A_A5A5, 32'd4, 32'd1);
        run_random(200);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_zero_limit();
        program_regs(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFE);
        run_random(200);
    endtask

    task automatic test_backpressure();
        program_regs($urandom, $urandom, $urandom, $urandom, 32'd6, 32'd1);
        tx_idle_on = 1'b0;
        rx_hold_requests++;
        run_random(200);
        tx_idle_on = 1'b1;
    endtask

    // receiver side of m_
    always @(posedge aclk) begin
        if (rx_hold_seen != rx_hold_requests) begin
            rx_hold_seen = rx_hold_requests;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(rx_idle_on && $urandom_range(99) < 9);
        end
    end

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
        end
    endfunction

    always @(posedge aclk) begin : result_check
        deframed_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_items.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected word, expected none actual %h last %b",
                         $time, m_tdata, m_tlast);
            end else begin
                want = expected_items.pop_front();
                check_field("item_kind", 32'(want.kind), 32'(m_tdata[3:0]));
                check_field("item_value", want.value, m_tdata[35:4]);
                check_field("status_code", 32'(want.status), 32'(m_tdata[38:36]));
                check_field("run_last", 32'(want.run_last), 32'(m_tlast));
                check_field("pad bit", 32'd0, 32'(m_tdata[39]));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_items.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        reg_magic = '0;
        reg_version = '0;
        reg_req_type = '0;
        reg_rsp_type = '0;
        reg_max_pay = 32'hFFFF_FFFF;
        reg_rsp_layout = 1'b0;
        clear_frame();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_short_header();
        test_header_checks();
        test_request_layout();
        test_oversize();
        test_response_layout();
        test_random_request();
        test_random_response_no_gaps();
        test_random_zero_limit();
        test_backpressure();

        drain_idle();
        if (mismatch_count == 0 && expected_items.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
